FILE: hdl/scm_pkg.sv
// Shared types and constants for the subpixel coverage mask unit.
// No dependencies; used by every module under hdl/.
package scm_pkg;

    localparam int EdgeW         = 16;
    localparam int MaskW         = 16;
    localparam int AreaW         = 8;
    localparam int NumMaskFields = 8;

    localparam logic [EdgeW-1:0] EdgeNone     = 16'hFFFF;
    localparam logic [EdgeW-1:0] EdgeFarRight = 16'h7FFF;

    typedef enum logic [2:0] {
        OP_BEGIN   = 3'd0,
        OP_LOAD    = 3'd1,
        OP_END     = 3'd2,
        OP_EVAL    = 3'd3,
        OP_UNCOVER = 3'd4
    } t_opcode;

    // command handed from the input stage to the span store
    typedef struct packed {
        logic                    go;
        logic [2:0]              op;
        logic [2:0]              row;
        logic signed [EdgeW-1:0] left;
        logic signed [EdgeW-1:0] right;
    } t_span_cmd;

endpackage

FILE: hdl/scm_span_store.sv
// Span store: per-subrow left/right edges plus the scanline extremes.
// Depends on scm_pkg (t_span_cmd, opcodes, edge constants).
module scm_span_store #(
    parameter int SUB_ROWS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scm_pkg::t_span_cmd               i_cmd,
    output logic signed [scm_pkg::EdgeW-1:0] o_left  [SUB_ROWS],
    output logic signed [scm_pkg::EdgeW-1:0] o_right [SUB_ROWS],
    output logic signed [scm_pkg::EdgeW-1:0] o_max_left,
    output logic signed [scm_pkg::EdgeW-1:0] o_min_right
);

    logic signed [scm_pkg::EdgeW-1:0] r_left  [SUB_ROWS];
    logic signed [scm_pkg::EdgeW-1:0] r_right [SUB_ROWS];
    logic signed [scm_pkg::EdgeW-1:0] r_max_left;
    logic signed [scm_pkg::EdgeW-1:0] r_min_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SUB_ROWS; r++) begin
                r_left[r]  <= scm_pkg::EdgeNone;
                r_right[r] <= scm_pkg::EdgeNone;
            end
            r_max_left  <= scm_pkg::EdgeNone;
            r_min_right <= scm_pkg::EdgeFarRight;
        end else if (i_cmd.go) begin
            unique case (i_cmd.op)
                scm_pkg::OP_BEGIN: begin
                    for (int r = 0; r < SUB_ROWS; r++) begin
                        r_left[r]  <= scm_pkg::EdgeNone;
                        r_right[r] <= scm_pkg::EdgeNone;
                    end
                    r_max_left  <= scm_pkg::EdgeNone;
                    r_min_right <= scm_pkg::EdgeFarRight;
                end
                scm_pkg::OP_LOAD: begin
                    // rows at or above SUB_ROWS match no entry and are dropped
                    if (32'(i_cmd.row) < SUB_ROWS) begin
                        for (int r = 0; r < SUB_ROWS; r++) begin
                            if (32'(i_cmd.row) == r) begin
                                r_left[r]  <= i_cmd.left;
                                r_right[r] <= i_cmd.right;
                            end
                        end
                        if (i_cmd.left > r_max_left)
                            r_max_left <= i_cmd.left;
                        if (i_cmd.right < r_min_right)
                            r_min_right <= i_cmd.right;
                    end
                end
                scm_pkg::OP_END: begin
                    r_max_left  <= scm_pkg::EdgeNone;
                    r_min_right <= scm_pkg::EdgeFarRight;
                end
                scm_pkg::OP_UNCOVER: begin
                    for (int r = 0; r < SUB_ROWS; r++) begin
                        if (32'(i_cmd.row) == r) begin
                            r_left[r]  <= scm_pkg::EdgeNone;
                            r_right[r] <= scm_pkg::EdgeNone;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_left      = r_left;
    assign o_right     = r_right;
    assign o_max_left  = r_max_left;
    assign o_min_right = r_min_right;

endmodule

FILE: hdl/scm_eval.sv
// Pixel evaluator: per-subrow coverage masks, row counts and the area sum.
// Depends on scm_pkg (field widths). Purely combinational.
module scm_eval #(
    parameter int SUB_ROWS = 8,
    parameter int SUB_COLS = 16
) (
    input  logic [14:0]                      i_px,
    input  logic signed [scm_pkg::EdgeW-1:0] i_left  [SUB_ROWS],
    input  logic signed [scm_pkg::EdgeW-1:0] i_right [SUB_ROWS],
    input  logic signed [scm_pkg::EdgeW-1:0] i_max_left,
    input  logic signed [scm_pkg::EdgeW-1:0] i_min_right,
    output logic [scm_pkg::AreaW-1:0]        o_area,
    output logic [scm_pkg::MaskW-1:0]        o_mask [scm_pkg::NumMaskFields]
);

    // signed column offset holding -1..SUB_COLS
    localparam int CW      = $clog2(SUB_COLS + 1) + 1;
    localparam int CntW    = $clog2(SUB_COLS + 1);
    localparam int SumW    = $clog2(SUB_ROWS * SUB_COLS + 1);
    localparam int FullArea = SUB_ROWS * SUB_COLS;

    localparam logic signed [16:0] ColsS   = 17'(SUB_COLS);
    localparam logic signed [16:0] ColsM1S = 17'(SUB_COLS - 1);

    logic signed [16:0]  px_s;
    logic                shortcut;
    logic [SUB_COLS-1:0] row_m [SUB_ROWS];
    logic [CntW-1:0]     cnt   [SUB_ROWS];
    logic [SumW-1:0]     sum;

    assign px_s = $signed({2'b00, i_px});

    // pixel strictly inside the scanline extremes: full coverage
    assign shortcut = (px_s > $signed({i_max_left[15], i_max_left}))
                   && (px_s < $signed({i_min_right[15], i_min_right}));

    for (genvar r = 0; r < SUB_ROWS; r++) begin : g_row
        logic signed [16:0]   dl;
        logic signed [16:0]   dr;
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;

        // column c is covered when dl <= c <= dr
        assign dl = $signed({i_left[r][15], i_left[r]}) - px_s;
        assign dr = $signed({i_right[r][15], i_right[r]}) - px_s;

        always_comb begin
            if (dl < 17'sd0)
                lo = '0;
            else if (dl > ColsS)
                lo = CW'(SUB_COLS);
            else
                lo = dl[CW-1:0];

            if (dr < -17'sd1)
                hi = '1;
            else if (dr > ColsM1S)
                hi = CW'(SUB_COLS - 1);
            else
                hi = dr[CW-1:0];

            for (int c = 0; c < SUB_COLS; c++)
                row_m[r][SUB_COLS-1-c] = (lo <= $signed(CW'(c))) && ($signed(CW'(c)) <= hi);

            cnt[r] = (hi >= lo) ? CntW'(hi - lo + 1) : '0;
        end
    end

    always_comb begin
        sum = '0;
        for (int r = 0; r < SUB_ROWS; r++)
            sum = sum + SumW'(cnt[r]);
    end

    assign o_area = shortcut ? scm_pkg::AreaW'(FullArea) : scm_pkg::AreaW'(sum);

    for (genvar k = 0; k < scm_pkg::NumMaskFields; k++) begin : g_mask
        if (k < SUB_ROWS) begin : g_used
            logic [SUB_COLS-1:0] sel;
            assign sel       = shortcut ? {SUB_COLS{1'b1}} : row_m[k];
            assign o_mask[k] = scm_pkg::MaskW'(sel);
        end else begin : g_unused
            assign o_mask[k] = '0;
        end
    end

endmodule

FILE: hdl/subpixel_coverage_mask_unit.sv
// Subpixel coverage mask unit: input stage, span store, evaluator, result register.
// Depends on scm_pkg, scm_span_store and scm_eval.
//
// Use: commands arrive on the input channel (i_in_valid / o_in_ready) as
// opcode, sub_row, span_left, span_right and pixel_x. Begin polygon, load
// span, end scanline and mark row uncovered update the span store and give
// no result. Evaluate pixel gives one result beat on the output channel
// (o_out_valid / i_out_ready): area and eight 16-bit subrow masks.
// An accepted beat is held in the input register; an evaluate's result
// is written to the result register as the beat leaves that stage. While
// the receiver keeps up, throughput is one item per cycle; the evaluator
// compares all subrows in parallel and sums the row counts in one pass
// between the two registers.
// A stalled receiver holds the result register; further non-evaluate
// beats still drain into the store, an evaluate waits in the input stage
// and the input channel stops once that stage is full.
// Reset (synchronous, active low) empties both stages, sets every span to
// -1, the greatest left edge to -1 and the least right edge to 0x7FFF.
module subpixel_coverage_mask_unit #(
    parameter int SUB_ROWS = 8,
    parameter int SUB_COLS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic [2:0]         i_sub_row,
    input  logic signed [15:0] i_span_left,
    input  logic signed [15:0] i_span_right,
    input  logic [14:0]        i_pixel_x,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_area,
    output logic [15:0]        o_mask_row_0,
    output logic [15:0]        o_mask_row_1,
    output logic [15:0]        o_mask_row_2,
    output logic [15:0]        o_mask_row_3,
    output logic [15:0]        o_mask_row_4,
    output logic [15:0]        o_mask_row_5,
    output logic [15:0]        o_mask_row_6,
    output logic [15:0]        o_mask_row_7
);

    logic               r_in_vld;
    logic [2:0]         r_op;
    logic [2:0]         r_row;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;
    logic [14:0]        r_px;

    logic                       r_out_vld;
    logic [scm_pkg::AreaW-1:0]  r_area;
    logic [scm_pkg::MaskW-1:0]  r_mask [scm_pkg::NumMaskFields];

    logic                       out_free;
    logic                       is_eval;
    logic                       s1_go;
    logic                       in_acc;
    scm_pkg::t_span_cmd         cmd;

    logic signed [scm_pkg::EdgeW-1:0] st_left  [SUB_ROWS];
    logic signed [scm_pkg::EdgeW-1:0] st_right [SUB_ROWS];
    logic signed [scm_pkg::EdgeW-1:0] st_max_left;
    logic signed [scm_pkg::EdgeW-1:0] st_min_right;
    logic [scm_pkg::AreaW-1:0]        ev_area;
    logic [scm_pkg::MaskW-1:0]        ev_mask [scm_pkg::NumMaskFields];

    assign out_free   = !r_out_vld || i_out_ready;
    assign is_eval    = (r_op == scm_pkg::OP_EVAL);
    // only an evaluate needs room in the result register
    assign s1_go      = r_in_vld && (!is_eval || out_free);
    assign o_in_ready = !r_in_vld || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (s1_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_opcode;
            r_row   <= i_sub_row;
            r_left  <= i_span_left;
            r_right <= i_span_right;
            r_px    <= i_pixel_x;
        end
    end

    assign cmd.go    = s1_go;
    assign cmd.op    = r_op;
    assign cmd.row   = r_row;
    assign cmd.left  = r_left;
    assign cmd.right = r_right;

    scm_span_store #(
        .SUB_ROWS (SUB_ROWS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_left      (st_left),
        .o_right     (st_right),
        .o_max_left  (st_max_left),
        .o_min_right (st_min_right)
    );

    scm_eval #(
        .SUB_ROWS (SUB_ROWS),
        .SUB_COLS (SUB_COLS)
    ) u_eval (
        .i_px        (r_px),
        .i_left      (st_left),
        .i_right     (st_right),
        .i_max_left  (st_max_left),
        .i_min_right (st_min_right),
        .o_area      (ev_area),
        .o_mask      (ev_mask)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && is_eval) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && is_eval) begin
            r_area <= ev_area;
            r_mask <= ev_mask;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_area       = r_area;
    assign o_mask_row_0 = r_mask[0];
    assign o_mask_row_1 = r_mask[1];
    assign o_mask_row_2 = r_mask[2];
    assign o_mask_row_3 = r_mask[3];
    assign o_mask_row_4 = r_mask[4];
    assign o_mask_row_5 = r_mask[5];
    assign o_mask_row_6 = r_mask[6];
    assign o_mask_row_7 = r_mask[7];

    // an evaluate blocked by a stalled result stays put in the input stage
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !s1_go) |=> (r_in_vld && $stable(r_op) && $stable(r_px)))
        else $error("input stage lost a blocked beat");

    // a result appears only from an evaluate or from a held result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(s1_go && is_eval) && !(r_out_vld && !i_out_ready)) |=> !r_out_vld)
        else $error("result beat without an evaluate");

    // begin polygon and end scanline restore both extremes
    a_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_op == scm_pkg::OP_BEGIN || r_op == scm_pkg::OP_END)) |=>
        (st_max_left == scm_pkg::EdgeNone && st_min_right == scm_pkg::EdgeFarRight))
        else $error("extremes not reset");

endmodule

FILE: tb/sv/tb_subpixel_coverage_mask_unit.sv
// Self-checking testbench for subpixel_coverage_mask_unit: a queue-fed driver,
// a monitor with its own coverage predictor, and idle/stall phases.
// Depends on scm_pkg and the subpixel_coverage_mask_unit RTL.
module tb_subpixel_coverage_mask_unit;

    localparam int SubRows = 8;
    localparam int SubCols = 16;
    localparam int PhaseItems = 400;
    localparam logic [2:0] OP_SPARE = 3'd5;  // 5..7 are unused opcodes

    typedef struct packed {
        logic [2:0]         opcode;
        logic [2:0]         sub_row;
        logic signed [15:0] span_left;
        logic signed [15:0] span_right;
        logic [14:0]        pixel_x;
    } t_coverage_cmd;

    typedef struct packed {
        logic [scm_pkg::AreaW-1:0]                             area;
        logic [scm_pkg::NumMaskFields-1:0][scm_pkg::MaskW-1:0] masks;
    } t_coverage_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          out_ready = 1'b0;
    logic          in_fire = 1'b0;
    t_coverage_cmd in_cmd = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [7:0]    o_area;
    logic [15:0]   o_mask_row [scm_pkg::NumMaskFields];

    t_coverage_cmd    pending_cmds [$];
    t_coverage_result expected_coverage [$];
    int               cmds_queued = 0;
    int               mismatches = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;

    // predictor copy of the span store
    logic signed [15:0] span_lo [SubRows];
    logic signed [15:0] span_hi [SubRows];
    logic signed [15:0] widest_left;
    logic signed [15:0] narrowest_right;

    subpixel_coverage_mask_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (in_cmd.opcode),
        .i_sub_row    (in_cmd.sub_row),
        .i_span_left  (in_cmd.span_left),
        .i_span_right (in_cmd.span_right),
        .i_pixel_x    (in_cmd.pixel_x),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_area       (o_area),
        .o_mask_row_0 (o_mask_row[0]),
        .o_mask_row_1 (o_mask_row[1]),
        .o_mask_row_2 (o_mask_row[2]),
        .o_mask_row_3 (o_mask_row[3]),
        .o_mask_row_4 (o_mask_row[4]),
        .o_mask_row_5 (o_mask_row[5]),
        .o_mask_row_6 (o_mask_row[6]),
        .o_mask_row_7 (o_mask_row[7])
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void reset_extremes();
        widest_left = scm_pkg::EdgeNone;
        narrowest_right = scm_pkg::EdgeFarRight;
    endfunction

    function automatic void clear_spans();
        for (int r = 0; r < SubRows; r++) begin
            span_lo[r] = scm_pkg::EdgeNone;
            span_hi[r] = scm_pkg::EdgeNone;
        end
    endfunction

    // Track the span store and queue the coverage an evaluate beat should give.
    function automatic void track_coverage_cmd(t_coverage_cmd c);
        t_coverage_result res;
        int px;
        int pos;
        int lo;
        int hi;
        int cnt;
        res = '0;
        cnt = 0;
        case (c.opcode)
            scm_pkg::OP_BEGIN: begin
                clear_spans();
                reset_extremes();
            end
            scm_pkg::OP_LOAD: begin
                span_lo[c.sub_row] = c.span_left;
                span_hi[c.sub_row] = c.span_right;
                if (c.span_left > widest_left) widest_left = c.span_left;
                if (c.span_right < narrowest_right) narrowest_right = c.span_right;
            end
            scm_pkg::OP_END: reset_extremes();
            scm_pkg::OP_UNCOVER: begin
                span_lo[c.sub_row] = scm_pkg::EdgeNone;
                span_hi[c.sub_row] = scm_pkg::EdgeNone;
            end
            scm_pkg::OP_EVAL: begin
                px = int'(c.pixel_x);
                lo = int'(widest_left);
                hi = int'(narrowest_right);
                if (px > lo && px < hi) begin
                    // strictly inside both extremes: full coverage, spans not consulted
                    cnt = SubRows * SubCols;
                    for (int r = 0; r < SubRows; r++) res.masks[r] = '1;
                end else begin
                    for (int r = 0; r < SubRows; r++) begin
                        lo = int'(span_lo[r]);
                        hi = int'(span_hi[r]);
                        for (int col = 0; col < SubCols; col++) begin
                            pos = px + col;
                            if (lo <= pos && pos <= hi) begin
                                res.masks[r][SubCols-1-col] = 1'b1;
                                cnt++;
                            end
                        end
                    end
                end
                res.area = scm_pkg::AreaW'(cnt);
                expected_coverage.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_cmd(logic [2:0] op, logic [2:0] row, int left, int right,
                                      int px);
        t_coverage_cmd c;
        c.opcode = op;
        c.sub_row = row;
        c.span_left = 16'(left);
        c.span_right = 16'(right);
        c.pixel_x = 15'(px);
        pending_cmds.push_back(c);
        if (op < OP_SPARE) cmds_queued++;
    endfunction

    // One scanline's worth: reset, spans clustered around a base x, a few
    // evaluations near the spans, then usually an end of scanline.
    task automatic queue_scanline_burst();
        int base;
        int lo;
        logic [2:0] first_op;
        base = $urandom_range(0, 32767);
        if ($urandom_range(0, 7) == 0)
            base = $urandom_range(0, 1) ? 0 : 32767 - $urandom_range(0, 20);
        first_op = ($urandom_range(0, 3) == 0) ? scm_pkg::OP_END : scm_pkg::OP_BEGIN;
        queue_cmd(first_op, 3'($urandom), $urandom, $urandom, $urandom);
        for (int r = 0; r < SubRows; r++) begin
            if ($urandom_range(0, 4) != 0) begin
                lo = base + $urandom_range(0, 24) - 8;
                queue_cmd(scm_pkg::OP_LOAD, 3'(r), lo, lo + $urandom_range(0, 24) - 4,
                          $urandom);
            end
        end
        if ($urandom_range(0, 2) == 0)
            queue_cmd(scm_pkg::OP_UNCOVER, 3'($urandom), $urandom, $urandom, $urandom);
        repeat ($urandom_range(2, 6))
            queue_cmd(scm_pkg::OP_EVAL, 3'($urandom), $urandom, $urandom,
                      base + $urandom_range(0, 40) - 16);
        if ($urandom_range(0, 3) != 0)
            queue_cmd(scm_pkg::OP_END, 3'($urandom), $urandom, $urandom, $urandom);
    endtask

    // driver: a beat is offered at the falling edge and held until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_cmd <= pending_cmds.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= i_rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: check result beats, then feed accepted input beats to the predictor
    always @(posedge i_clk) begin
        t_coverage_result got;
        t_coverage_result want;
        logic bad;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            clear_spans();
            reset_extremes();
        end else begin
            in_fire <= in_valid && o_in_ready;
            if (o_out_valid && out_ready) begin
                got.area = o_area;
                for (int r = 0; r < scm_pkg::NumMaskFields; r++)
                    got.masks[r] = o_mask_row[r];
                if (expected_coverage.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: area %0d masks %h", got.area,
                                 got.masks);
                end else begin
                    want = expected_coverage.pop_front();
                    bad = (got.area !== want.area);
                    for (int r = 0; r < scm_pkg::NumMaskFields; r++)
                        bad = bad || (got.masks[r] !== want.masks[r]);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected area %0d masks %h, got %0d masks %h",
                                     want.area, want.masks, got.area, got.masks);
                    end
                end
            end
            if (in_valid && o_in_ready) track_coverage_cmd(in_cmd);
        end
    end

    initial begin
        int idle_tab [4];
        int stall_tab [4];
        int target;
        idle_tab = '{0, 74, 0, 9};
        stall_tab = '{0, 0, 74, 9};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            @(posedge i_clk);
            send_idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph == 0) begin
                // straight after reset: inside both extremes, then on the right one
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 0);
                queue_cmd(scm_pkg::OP_EVAL, 7, -1, -1, 32767);
                queue_cmd(OP_SPARE, 7, -1, -1, 32767);
                queue_cmd(OP_SPARE + 3'd1, 0, 0, 0, 0);
                queue_cmd(OP_SPARE + 3'd2, 5, 12345, -12345, 777);
                queue_cmd(scm_pkg::OP_LOAD, 0, 0, 15, 0);
                queue_cmd(scm_pkg::OP_LOAD, 1, 8, 20, 0);
                queue_cmd(scm_pkg::OP_LOAD, 2, -32768, 32767, 32767);
                queue_cmd(scm_pkg::OP_LOAD, 3, 20, 10, 0);       // reversed span
                queue_cmd(scm_pkg::OP_LOAD, 4, 32767, 32767, 0);
                queue_cmd(scm_pkg::OP_LOAD, 5, -1, -1, 0);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 0);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 8);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 32767);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 32760);
                queue_cmd(scm_pkg::OP_UNCOVER, 2, 32767, 32767, 0);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 0);
                queue_cmd(scm_pkg::OP_END, 0, 0, 0, 0);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 4);          // full-coverage shortcut
                queue_cmd(scm_pkg::OP_LOAD, 6, 4, 4, 0);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 0);
                queue_cmd(scm_pkg::OP_BEGIN, 7, -1, -1, 32767);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 16);
                queue_cmd(scm_pkg::OP_LOAD, 7, 32767, -1, 0);
                queue_cmd(scm_pkg::OP_EVAL, 0, 0, 0, 32767);
            end
            target = cmds_queued + PhaseItems;
            while (cmds_queued < target) begin
                if ($urandom_range(0, 9) < 8) queue_scanline_burst();
                else queue_cmd(3'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
            end
            // sender holds off until every outstanding result is back
            while (pending_cmds.size() != 0 || in_valid || expected_coverage.size() != 0)
                @(posedge i_clk);
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_subpixel_coverage_mask_unit passed");
        else
            $display("tb_subpixel_coverage_mask_unit failed");
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_subpixel_coverage_mask_unit failed");
        $finish;
    end

endmodule
